FILE: src/edd_pkg.sv
`default_nettype none
package edd_pkg;

	// Line store depth and derived widths
	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int WE_W      = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W     = (WE_W > 12) ? WE_W : 12;

	// Register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BLACK_BELOW  = 2'd2;

	// Register reset values
	localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd480;
	localparam logic [7:0]  RST_BLACK_BELOW  = 8'd126;

	// Luma weights, Q0.16 (sum is 65536)
	localparam logic [15:0] W_RED   = 16'd19595;
	localparam logic [15:0] W_GREEN = 16'd38470;
	localparam logic [15:0] W_BLUE  = 16'd7471;

	localparam logic [8:0] WHITE_LEVEL = 9'd255;

endpackage
`default_nettype wire

FILE: src/error_diffusion_dither_core.sv
`default_nettype none
// Error-diffusion dither core: RGB pixels in, one black/white pixel out per pixel.
//
// Input stream: s_axis_* carries one RGB pixel per item, raster order, frame
// geometry from the image_width / image_height registers. Output stream:
// m_axis_* carries one item per pixel; tdata[0] is 1 for white, tlast marks
// the last pixel of the frame.
// Config: cfg_we writes cfg_wdata into register cfg_index (0 width, 1 height,
// 2 black threshold). The user writes only while the core is idle; the core
// does not enforce it. Index 3 is ignored.
// Throughput: one pixel per clock while m_axis_tready is high. The limit is the single
// read-modify-write of the line store (one read, one write port per cycle)
// and the right-carry loop in the update stage.
// Path: an accepted item passes the stage 1 registers, then the output register,
// which presents it on m_axis.
// Stall: when m_axis_tready is low the output register holds, the update
// stage fills, then s_axis_tready drops; nothing is lost or repeated.
// Reset: arst_n clears position, carries and valid flags and restores the
// register defaults. The line store is not cleared: row 0 never uses it,
// and every later read hits an entry written one row earlier.
module error_diffusion_dither_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// pixel in
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
	// pixel out
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // pixel_white[0], zero pad [7:1]
	output logic             m_axis_tlast,   // frame_end
	// config
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	localparam int AW = edd_pkg::ADDR_W;
	localparam int CW = edd_pkg::CMP_W;

	// ---------------- config registers ----------------
	logic [11:0] image_width_q;
	logic [15:0] image_height_q;
	logic [7:0]  black_below_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= edd_pkg::RST_IMAGE_WIDTH;
			image_height_q <= edd_pkg::RST_IMAGE_HEIGHT;
			black_below_q  <= edd_pkg::RST_BLACK_BELOW;
		end else if (cfg_we) begin
			case (cfg_index)
				edd_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[11:0];
				edd_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata;
				edd_pkg::REG_BLACK_BELOW:  black_below_q  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	logic in_acc;
	logic s1_valid_q;
	logic s1_go;
	logic out_valid_q;

	assign s1_go         = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || s1_go;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// ---------------- stage 0: position, luma, line store read ----------------
	logic [AW-1:0] col_q;
	logic [15:0]   row_q;

	logic [CW-1:0] we_c;      // effective width
	logic [15:0]   he_c;      // effective height
	logic [CW-1:0] col_ext;
	logic [CW-1:0] col_cl;
	logic [AW-1:0] col_c;
	logic          last_col_c;
	logic          last_row_c;
	logic [23:0]   luma_sum;

	always_comb begin
		if (image_width_q == 12'd0)
			we_c = CW'(1);
		else if (CW'(image_width_q) > CW'(edd_pkg::MAX_WIDTH))
			we_c = CW'(edd_pkg::MAX_WIDTH);
		else
			we_c = CW'(image_width_q);
		he_c = (image_height_q == 16'd0) ? 16'd1 : image_height_q;

		col_ext    = CW'(col_q);
		col_cl     = (col_ext >= we_c) ? (we_c - CW'(1)) : col_ext;
		col_c      = col_cl[AW-1:0];
		last_col_c = ({1'b0, col_cl} + (CW+1)'(1)) >= {1'b0, we_c};
		last_row_c = ({1'b0, row_q} + 17'd1) >= {1'b0, he_c};

		luma_sum = 24'(edd_pkg::W_RED)   * 24'(s_axis_tdata[7:0])
		         + 24'(edd_pkg::W_GREEN) * 24'(s_axis_tdata[15:8])
		         + 24'(edd_pkg::W_BLUE)  * 24'(s_axis_tdata[23:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col_c) begin
				col_q <= '0;
				row_q <= last_row_c ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_c + AW'(1);
			end
		end
	end

	// ---------------- stage 1 registers ----------------
	logic [AW-1:0] col_s1;
	logic [7:0]    gray_s1;
	logic          last_col_s1;
	logic          last_row_s1;
	logic          row_zero_s1;
	logic          col_zero_s1;
	logic          fwd_s1;
	logic [15:0]   fwd_data_s1;
	logic [15:0]   rdata_s1;

	logic [15:0]   wdata_c;
	logic          fwd_hit;

	// Back-to-back access to one entry only happens at width 1: bypass the write.
	assign fwd_hit = s1_go && (col_s1 == col_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_acc)
			s1_valid_q <= 1'b1;
		else if (s1_go)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_s1      <= col_c;
			gray_s1     <= luma_sum[23:16];
			last_col_s1 <= last_col_c;
			last_row_s1 <= last_row_c;
			row_zero_s1 <= (row_q == 16'd0);
			col_zero_s1 <= (col_c == '0);
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= wdata_c;
		end
	end

	// Line store: {diagonal share, down share} per column for the next row.
	logic [15:0] line_mem [edd_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (s1_go)
			line_mem[col_s1] <= wdata_c;
		if (in_acc)
			rdata_s1 <= line_mem[col_c];
	end

	// ---------------- stage 1: diffuse ----------------
	logic [7:0] right_carry_q;
	logic [7:0] diag_carry_q;

	function automatic logic signed [9:0] add_sat(input logic signed [9:0] a,
	                                              input logic [7:0] c);
		logic signed [9:0] s;
		s = a + $signed({{2{c[7]}}, c});
		if (s < 10'sd0)
			s = 10'sd0;
		else if (s > 10'sd255)
			s = 10'sd255;
		return s;
	endfunction

	logic [15:0]        entry_c;
	logic [7:0]         right_in_c;
	logic signed [9:0]  v1_c, v2_c, v3_c;
	logic               white_c;
	logic [8:0]         err_c;
	logic signed [10:0] t3_c;
	logic signed [9:0]  t4_c;
	logic [7:0]         to_right_c, to_down_c, to_diag_c;
	logic               no_diffuse_c;

	always_comb begin
		entry_c    = fwd_s1 ? fwd_data_s1 : rdata_s1;
		if (row_zero_s1)
			entry_c = 16'd0;
		right_in_c = col_zero_s1 ? 8'd0 : right_carry_q;

		// diagonal, then down, then right, saturating after each
		v1_c = add_sat($signed({2'b00, gray_s1}), entry_c[15:8]);
		v2_c = add_sat(v1_c, entry_c[7:0]);
		v3_c = add_sat(v2_c, right_in_c);

		white_c = v3_c[7:0] >= black_below_q;
		err_c   = white_c ? ({1'b0, v3_c[7:0]} - edd_pkg::WHITE_LEVEL) : {1'b0, v3_c[7:0]};

		// round-half-up shares: floor((3e+4)/8), floor((e+2)/4)
		t3_c = ($signed({{2{err_c[8]}}, err_c}) <<< 1) + $signed({{2{err_c[8]}}, err_c})
		     + 11'sd4;
		t4_c = $signed({err_c[8], err_c}) + 10'sd2;

		no_diffuse_c = last_col_s1 || last_row_s1;
		to_right_c   = no_diffuse_c ? 8'd0 : 8'(t3_c >>> 3);
		to_down_c    = to_right_c;
		to_diag_c    = no_diffuse_c ? 8'd0 : 8'(t4_c >>> 2);

		wdata_c = {(col_zero_s1 ? 8'd0 : diag_carry_q), to_down_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_carry_q <= '0;
			diag_carry_q  <= '0;
		end else if (s1_go) begin
			right_carry_q <= last_col_s1 ? 8'd0 : to_right_c;
			diag_carry_q  <= last_col_s1 ? 8'd0 : to_diag_c;
		end
	end

	// ---------------- output register ----------------
	logic white_q;
	logic frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_go)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			white_q     <= white_c;
			frame_end_q <= last_col_s1 && last_row_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, white_q};
	assign m_axis_tlast  = frame_end_q;

	// ---------------- assertions ----------------
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_col_c |=> col_q == '0)
		else $error("column did not wrap after last column");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while update stage is blocked");

	a_fwd_on_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s1_go && (col_s1 == col_c) |=> fwd_s1)
		else $error("line store write not bypassed to same-entry read");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> m_axis_tvalid)
		else $error("finished item not presented on output");

endmodule
`default_nettype wire

FILE: sim/tb_error_diffusion_dither_core.sv
typedef struct packed {
	logic white;
	logic frame_end;
} dither_result_t;

// Predicts the dithered stream from the register values and the accepted pixels,
// holds the results still to come, and checks them in order.
class dither_scoreboard;
	logic [11:0] width_reg;
	logic [15:0] height_reg;
	logic [7:0]  black_below;
	int unsigned col;
	int unsigned row;
	logic [15:0] below_line [edd_pkg::MAX_WIDTH];   // {diag share, down share} per column
	logic [7:0]  right_share;
	logic [7:0]  diag_share;
	dither_result_t expected_pixels[$];
	int unsigned mismatches;
	int unsigned results_checked;
	int unsigned frames_seen;

	function new();
		width_reg       = edd_pkg::RST_IMAGE_WIDTH;
		height_reg      = edd_pkg::RST_IMAGE_HEIGHT;
		black_below     = edd_pkg::RST_BLACK_BELOW;
		col             = 0;
		row             = 0;
		right_share     = 8'h00;
		diag_share      = 8'h00;
		mismatches      = 0;
		results_checked = 0;
		frames_seen     = 0;
	endfunction

	function void set_register(logic [1:0] index, logic [15:0] value);
		case (index)
		edd_pkg::REG_IMAGE_WIDTH: width_reg = value[11:0];
		edd_pkg::REG_IMAGE_HEIGHT: height_reg = value;
		edd_pkg::REG_BLACK_BELOW: black_below = value[7:0];
		default: ;
		endcase
	endfunction

	function int unsigned clamp_width(logic [11:0] w);
		if (w == 0)
			return 1;
		if (w > edd_pkg::MAX_WIDTH)
			return edd_pkg::MAX_WIDTH;
		return 32'(w);
	endfunction

	function int unsigned active_height();
		return (height_reg == 0) ? 1 : 32'(height_reg);
	endfunction

	function bit at_frame_start();
		return (col == 0) && (row == 0);
	endfunction

	function int unsigned pixels_to_frame_end();
		int unsigned we;
		int unsigned he;
		int unsigned c;
		int unsigned rows_after;
		we = clamp_width(width_reg);
		he = active_height();
		c = (col >= we) ? we - 1 : col;
		rows_after = (row + 1 >= he) ? 0 : he - 1 - row;
		return rows_after * we + (we - c);
	endfunction

	function int sat_add(int v, int c);
		v += c;
		if (v < 0)
			return 0;
		if (v > 255)
			return 255;
		return v;
	endfunction

	function void dither_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int unsigned we;
		int unsigned he;
		int unsigned c;
		int level;
		int err;
		int diag_in;
		int down_in;
		int right_in;
		int to_right;
		int to_down;
		int to_diag;
		bit last_col;
		bit last_row;
		bit white;
		dither_result_t res;
		we = clamp_width(width_reg);
		he = active_height();
		c = (col >= we) ? we - 1 : col;
		last_col = (c + 1 >= we);
		last_row = (row + 1 >= he);
		level = (int'(edd_pkg::W_RED) * int'(r) + int'(edd_pkg::W_GREEN) * int'(g)
			+ int'(edd_pkg::W_BLUE) * int'(b)) >> 16;
		diag_in = 0;
		down_in = 0;
		right_in = 0;
		if (row != 0) begin
			diag_in = int'($signed(below_line[c][15:8]));
			down_in = int'($signed(below_line[c][7:0]));
		end
		if (c != 0)
			right_in = int'($signed(right_share));
		level = sat_add(level, diag_in);
		level = sat_add(level, down_in);
		level = sat_add(level, right_in);
		white = !(level < int'(black_below));
		err = white ? level - 255 : level;
		to_right = 0;
		to_down = 0;
		to_diag = 0;
		if (!last_col && !last_row) begin
			to_right = (3 * err + 4) >>> 3;
			to_down = to_right;
			to_diag = (err + 2) >>> 2;
		end
		below_line[c] = {(c != 0) ? diag_share : 8'h00, to_down[7:0]};
		right_share = to_right[7:0];
		diag_share = to_diag[7:0];
		res.white = white;
		res.frame_end = last_col && last_row;
		expected_pixels.push_back(res);
		if (res.frame_end)
			frames_seen++;
		if (last_col) begin
			col = 0;
			right_share = 8'h00;
			diag_share = 8'h00;
			row = last_row ? 0 : ((row + 1) & 32'hFFFF);
		end else begin
			col = c + 1;
		end
	endfunction

	task report_mismatch(string what);
		mismatches++;
		$display("MISMATCH at result %0d: %s", results_checked, what);
	endtask

	task check_pixel(logic [7:0] data, logic last);
		dither_result_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch($sformatf("item with none pending, data=%h last=%b", data, last));
			return;
		end
		want = expected_pixels.pop_front();
		if (data[0] !== want.white)
			report_mismatch($sformatf("pixel_white %b, want %b", data[0], want.white));
		if (data[7:1] !== 7'd0)
			report_mismatch($sformatf("pad bits %h, want 0", data[7:1]));
		if (last !== want.frame_end)
			report_mismatch($sformatf("frame_end %b, want %b", last, want.frame_end));
		results_checked++;
	endtask
endclass

module tb_error_diffusion_dither_core;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned PIXEL_TARGET    = 700;
	localparam int unsigned HOLD_OFF_CYCLES = 60;
	localparam logic [1:0]  REG_SPARE       = 2'd3;   // unmapped index, must be ignored

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = 24'h000000;   // red[7:0], green[15:8], blue[23:16]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;                 // pixel_white[0], pad[7:1]
	logic        m_axis_tlast;                 // frame_end
	logic        cfg_we        = 1'b0;
	logic [1:0]  cfg_index     = 2'd0;
	logic [15:0] cfg_wdata     = 16'h0000;

	dither_scoreboard sb = new();

	// idle_pct: chance in percent that a side starts an idle burst; 0 runs flat out
	int unsigned idle_pct     = 0;
	int unsigned hold_left    = 0;   // long output hold-off, counted down by the receiver
	int unsigned stall_left   = 0;
	int unsigned pixels_sent  = 0;
	int unsigned settings_used = 0;
	int unsigned cycle_count  = 0;

	error_diffusion_dither_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: the long hold-off wins, then random stall bursts.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			m_axis_tready <= 1'b0;
			stall_left = $urandom_range(10);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Output side is sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_pixel(m_axis_tdata, m_axis_tlast);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("error_diffusion_dither_core verification failed");
		$finish;
	end

	// Register write; the model takes the value at the edge that writes it.
	task automatic write_reg(logic [1:0] index, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_register(index, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one pixel, maybe after an idle burst, and hold it until taken.
	task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int unsigned gap;
		@(negedge clk);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 11);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, g, r};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.dither_pixel(r, g, b);
		pixels_sent++;
	endtask

	task automatic stop_pixels();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	// Mix of plain random color, flat grays and saturated channels (large errors).
	task automatic send_pixels(int unsigned count);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		repeat (count) begin
			case ($urandom_range(6))
			0: begin
				r = 8'($urandom);
				g = r;
				b = r;
			end
			1: begin
				r = $urandom_range(1) ? 8'hFF : 8'h00;
				g = $urandom_range(1) ? 8'hFF : 8'h00;
				b = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			default: begin
				r = 8'($urandom);
				g = 8'($urandom);
				b = 8'($urandom);
			end
			endcase
			push_pixel(r, g, b);
		end
		stop_pixels();
	endtask

	task automatic wait_drained();
		while (sb.expected_pixels.size() != 0) @(posedge clk);
	endtask

	// New register setting, written only with nothing in flight.
	task automatic configure(logic [15:0] width_word, logic [15:0] height_word,
			logic [15:0] thr_word);
		wait_drained();
		// Widening mid-frame would read line store columns this frame never wrote:
		// make the current row the last one and finish the frame first.
		if (sb.clamp_width(width_word[11:0]) > sb.clamp_width(sb.width_reg)
				&& !sb.at_frame_start()) begin
			write_reg(edd_pkg::REG_IMAGE_HEIGHT, 16'd1);
			send_pixels(sb.pixels_to_frame_end());
			wait_drained();
		end
		write_reg(edd_pkg::REG_IMAGE_WIDTH, width_word);
		write_reg(edd_pkg::REG_IMAGE_HEIGHT, height_word);
		write_reg(edd_pkg::REG_BLACK_BELOW, thr_word);
		if ($urandom_range(3) == 0)
			write_reg(REG_SPARE, 16'($urandom_range(16'hFFFF)));
		settings_used++;
	endtask

	initial begin
		logic [11:0] w12;
		logic [15:0] h16;
		logic [7:0] thr;
		logic [3:0] junk_hi;
		logic [7:0] junk_lo;
		int unsigned left;
		int unsigned count;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ---- directed ----
		idle_pct = 25;
		// power-on registers: black, white, pure red
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'hFF, 8'h00, 8'h00);
		stop_pixels();
		// narrow to 3 while at column 3: position lands past the last column
		configure(16'd3, 16'd3, 16'd126);
		send_pixels(sb.pixels_to_frame_end());
		// width and height zero act as 1x1; threshold 0 makes everything white
		configure(16'd0, 16'd0, 16'd0);
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'h11, 8'hC8, 8'h03);
		stop_pixels();
		// threshold 255: only full white stays white
		configure(16'h0000, 16'd0, 16'd255);
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_pixel(8'hFE, 8'hFE, 8'hFE);
		stop_pixels();
		// width field 4095 clamps to the line store depth; junk in the upper bits
		configure(16'hFFFF, 16'd2, 16'hA57E);
		send_pixels(3);
		// shrink mid-row to 2 columns, then finish that frame
		configure(16'd2, 16'd2, 16'd128);
		send_pixels(sb.pixels_to_frame_end());
		// tallest frame, one column wide; then cut it short by lowering the height
		configure(16'd1, 16'd65535, 16'd126);
		send_pixels(3);
		configure(16'd1, 16'd2, 16'd126);
		send_pixels(sb.pixels_to_frame_end());

		// ---- backpressure: output held off while input keeps coming ----
		idle_pct = 0;
		configure(16'd6, 16'd5, 16'($urandom_range(255)));
		hold_left = HOLD_OFF_CYCLES;
		send_pixels(sb.pixels_to_frame_end());

		// ---- random frames ----
		while (pixels_sent < PIXEL_TARGET) begin
			case ($urandom_range(3))
			0: idle_pct = 0;
			1: idle_pct = 10;
			2: idle_pct = 30;
			default: idle_pct = 60;
			endcase
			junk_hi = 4'($urandom_range(15));
			junk_lo = 8'($urandom_range(255));
			case ($urandom_range(9))
			7: w12 = 12'd0;
			8: w12 = 12'd1;
			9: w12 = 12'($urandom_range(10, 40));
			default: w12 = 12'($urandom_range(2, 9));
			endcase
			case ($urandom_range(9))
			6: h16 = 16'd0;
			7: h16 = 16'($urandom_range(7, 30));
			8: h16 = 16'd65535;
			9: h16 = 16'($urandom_range(1, 65535));
			default: h16 = 16'($urandom_range(1, 6));
			endcase
			case ($urandom_range(9))
			6: thr = 8'd0;
			7: thr = 8'd255;
			8: thr = 8'd1;
			9: thr = 8'($urandom_range(100, 160));
			default: thr = 8'($urandom_range(255));
			endcase
			configure({junk_hi, w12}, h16, {junk_lo, thr});
			left = sb.pixels_to_frame_end();
			if (left > 150)
				count = $urandom_range(20, 100);
			else case ($urandom_range(3))
				0: count = $urandom_range(1, left);
				1: count = left + $urandom_range(1, 20);
				default: count = left;
			endcase
			send_pixels(count);
		end

		// ---- closing frame, no idling on either side ----
		idle_pct = 0;
		stall_left = 0;
		configure(16'd5, 16'd4, 16'($urandom_range(255)));
		send_pixels(sb.pixels_to_frame_end());

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Dithered %0d pixels over %0d frames and %0d register settings,",
			pixels_sent, sb.frames_seen, settings_used);
		$display("incl. clamped sizes, mid-frame resizes and a %0d-cycle output hold; %0d mismatches.",
			HOLD_OFF_CYCLES, sb.mismatches);
		if (sb.mismatches == 0)
			$display("error_diffusion_dither_core verification clean");
		else
			$display("error_diffusion_dither_core verification failed");
		$finish;
	end
endmodule

FILE: error_diffusion_dither_core.f
src/edd_pkg.sv
src/error_diffusion_dither_core.sv
sim/tb_error_diffusion_dither_core.sv
